@@ hdl/skcr_pkg.sv @@
// Shared constants and types for the serial keyboard code receiver.
`timescale 1ns / 1ps

package skcr_pkg;

   localparam int CodeWidth     = 29;
   localparam int CodeWordWidth = 32;
   localparam int GapWidth      = 8;
   localparam int IdleWidth     = 8;
   localparam int CmdWidth      = 2;
   localparam int ShortCode     = 3;

   localparam logic [GapWidth-1:0]  GapReset = 8'd16;
   localparam logic [IdleWidth-1:0] IdleMax  = 8'd255;

   typedef logic [CmdWidth-1:0]  cmd_type;
   typedef logic [CodeWidth-1:0] code_type;
   typedef logic [GapWidth-1:0]  gap_type;

   localparam cmd_type CMD_EDGE = 2'd0;
   localparam cmd_type CMD_TICK = 2'd1;
   localparam cmd_type CMD_READ = 2'd2;

endpackage

@@ hdl/skcr_if.sv @@
// Valid/ready channel interfaces for requests, responses and the gap register.
`timescale 1ns / 1ps

interface skcr_req_if;
   import skcr_pkg::*;
   logic    valid;
   logic    ready;
   cmd_type command;
   logic    data_bit;
   modport source (output valid, output command, output data_bit, input ready);
   modport sink (input valid, input command, input data_bit, output ready);
endinterface

interface skcr_rsp_if;
   import skcr_pkg::*;
   logic     valid;
   logic     ready;
   code_type code;
   logic     code_present;
   modport source (output valid, output code, output code_present, input ready);
   modport sink (input valid, input code, input code_present, output ready);
endinterface

interface skcr_csr_if;
   import skcr_pkg::*;
   logic    valid;
   logic    ready;
   gap_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/serial_keyboard_code_receiver_unit.sv @@
// Top level of the serial keyboard code receiver with its code FIFO.
//
// The req channel carries one word per event: a falling keyboard clock edge with
// its data bit, a millisecond tick, or a request to read the next code. Edges and
// reads first close the pending bits into a code when more than gap_ticks ticks
// have passed since the last edge or read. Each read returns one word on the rsp
// channel with the oldest code, shifted right by one and cut to its size minus
// three bits, or zero with code_present low when the FIFO is empty. Edges and
// ticks return nothing. A code that completes while the FIFO is full is dropped.
// The csr channel writes gap_ticks and is ready whenever reset is low; write it
// only while idle. A word is taken every cycle unless a read is held in the input
// register. A read passes through the input register, the registered FIFO memory
// read and the output register on its way to rsp. The rsp word is held in the output
// register, so while it waits, edges and ticks keep flowing and a further read is
// held only when the memory read stage is also occupied.
// Reset is synchronous and clears the pipeline, the pending bits, the idle
// count and the FIFO pointers, and sets gap_ticks to 16. FIFO memory has no reset.
// Both the req and the csr channel are held not ready while reset is high.
`timescale 1ns / 1ps

module serial_keyboard_code_receiver_unit #(
   parameter int FIFO_DEPTH = 16,
   parameter int MAX_BITS   = 32
) (
   input logic          clock,
   input logic          reset,
   skcr_req_if.sink     req,
   skcr_rsp_if.source   rsp,
   skcr_csr_if.sink     csr
);
   import skcr_pkg::*;

   localparam int PtrWidth  = $clog2(FIFO_DEPTH);
   localparam int CntWidth  = $clog2(FIFO_DEPTH + 1);
   localparam int SizeWidth = $clog2(MAX_BITS + 1);
   localparam int EntryWidth = MAX_BITS + SizeWidth;

   logic [PtrWidth-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic [MAX_BITS-1:0]   shift_ff, shift_in;
   logic [SizeWidth-1:0]  pend_ff, pend_in;
   logic [IdleWidth-1:0]  idle_ff, idle_in;
   gap_type               gap_ff;

   logic                  a_valid_ff;
   cmd_type               a_cmd_ff;
   logic                  a_bit_ff;

   logic                  b_valid_ff, b_present_ff, b_bypass_ff;
   logic [MAX_BITS-1:0]   b_code_ff;
   logic [SizeWidth-1:0]  b_size_ff;
   logic [EntryWidth-1:0] mem_rd_ff;
   logic [EntryWidth-1:0] fifo_mem [FIFO_DEPTH];

   logic                  rsp_valid_ff, rsp_present_ff;
   code_type              rsp_code_ff, rsp_code_in;

   logic                  rsp_adv, b_free, a_go, accept;
   logic                  close, push, pop, bypass;

   assign rsp_adv = !rsp_valid_ff || rsp.ready;
   assign b_free  = !b_valid_ff || rsp_adv;
   assign a_go    = a_valid_ff && (a_cmd_ff != CMD_READ || b_free);
   assign req.ready = !reset && (!a_valid_ff || a_go);
   assign accept  = req.valid && req.ready;
   assign csr.ready = !reset;

   always_comb begin
      logic [CntWidth-1:0]  cnt_after;
      logic [MAX_BITS-1:0]  sh;
      logic [SizeWidth-1:0] pd;
      close     = 1'b0;
      push      = 1'b0;
      pop       = 1'b0;
      bypass    = 1'b0;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      pend_in   = pend_ff;
      idle_in   = idle_ff;
      cnt_after = count_ff;
      sh        = shift_ff;
      pd        = pend_ff;
      if (a_go && (a_cmd_ff == CMD_EDGE || a_cmd_ff == CMD_READ)) begin
         close   = (idle_ff > gap_ff) && (pend_ff != '0);
         push    = close && (count_ff != CntWidth'(FIFO_DEPTH));
         idle_in = '0;
         if (close) begin
            sh = '0;
            pd = '0;
         end
         if (push) begin
            cnt_after = count_ff + CntWidth'(1);
            tail_in = (tail_ff == PtrWidth'(FIFO_DEPTH - 1)) ? '0 : tail_ff + PtrWidth'(1);
         end
      end
      if (a_go) begin
         unique case (a_cmd_ff)
            CMD_EDGE: begin
               if (pd != SizeWidth'(MAX_BITS)) begin
                  sh = {sh[MAX_BITS-2:0], a_bit_ff};
                  pd = pd + SizeWidth'(1);
               end
            end
            CMD_TICK: begin
               if (idle_ff != IdleMax) begin
                  idle_in = idle_ff + IdleWidth'(1);
               end
            end
            CMD_READ: begin
               pop    = cnt_after != '0;
               bypass = push && (count_ff == '0);
               if (pop) begin
                  cnt_after = cnt_after - CntWidth'(1);
                  head_in = (head_ff == PtrWidth'(FIFO_DEPTH - 1)) ? '0 : head_ff + PtrWidth'(1);
               end
            end
            default: begin
            end
         endcase
      end
      count_in = cnt_after;
      shift_in = sh;
      pend_in  = pd;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[tail_ff] <= {pend_ff, shift_ff};
      end
      if (pop) begin
         mem_rd_ff <= fifo_mem[head_ff];
      end
   end

   always_comb begin
      logic [MAX_BITS-1:0]      c;
      logic [SizeWidth-1:0]     s;
      logic [CodeWordWidth-1:0] word;
      logic [CodeWidth:0]       mask;
      if (b_bypass_ff) begin
         c = b_code_ff;
         s = b_size_ff;
      end else begin
         c = mem_rd_ff[MAX_BITS-1:0];
         s = mem_rd_ff[EntryWidth-1:MAX_BITS];
      end
      word = CodeWordWidth'(c);
      mask = ((CodeWidth + 1)'(1) << (s - SizeWidth'(ShortCode))) - (CodeWidth + 1)'(1);
      if (!b_present_ff || s < SizeWidth'(ShortCode)) begin
         rsp_code_in = '0;
      end else begin
         rsp_code_in = word[CodeWidth:1] & mask[CodeWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         shift_ff     <= '0;
         pend_ff      <= '0;
         idle_ff      <= '0;
         gap_ff       <= GapReset;
      end else begin
         if (csr.valid) begin
            gap_ff <= csr.data;
         end
         if (req.ready) begin
            a_valid_ff <= req.valid;
         end
         if (a_go && a_cmd_ff == CMD_READ) begin
            b_valid_ff <= 1'b1;
         end else if (rsp_adv) begin
            b_valid_ff <= 1'b0;
         end
         if (b_valid_ff && rsp_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         pend_ff  <= pend_in;
         idle_ff  <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_cmd_ff <= req.command;
         a_bit_ff <= req.data_bit;
      end
      if (a_go && a_cmd_ff == CMD_READ) begin
         b_present_ff <= pop;
         b_bypass_ff  <= bypass;
         b_code_ff    <= shift_ff;
         b_size_ff    <= pend_ff;
      end
      if (b_valid_ff && rsp_adv) begin
         rsp_code_ff    <= rsp_code_in;
         rsp_present_ff <= b_present_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.code         = rsp_code_ff;
   assign rsp.code_present = rsp_present_ff;

   // The occupancy never goes beyond the FIFO depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(FIFO_DEPTH))
      else $error("FIFO count beyond depth");

   // An empty read always answers with a zero code.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_present_ff |-> rsp_code_ff == '0)
      else $error("empty read with nonzero code");

   // Head and tail meet exactly when the FIFO is empty or full.
   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (head_ff == tail_ff) == (count_ff == '0 || count_ff == CntWidth'(FIFO_DEPTH)))
      else $error("FIFO pointers disagree with count");

   // A write bypass only happens for a read that found the FIFO empty.
   a_bypass_empty: assert property (@(posedge clock) disable iff (reset)
      a_go && bypass |-> count_ff == '0 && pop)
      else $error("bypass on nonempty FIFO");

   // Reset leaves no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !b_valid_ff && count_ff == '0)
      else $error("state not cleared by reset");

endmodule
